// ===== src/sorted_alarm_queue_assert.svh =====
// assertion macros for the sorted alarm queue
`ifndef SORTED_ALARM_QUEUE_ASSERT_SVH
`define SORTED_ALARM_QUEUE_ASSERT_SVH

`ifndef SYNTH
// expression must hold at every clock edge out of reset
`define SAQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define SAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SAQ_ASSERT_ALWAYS(lbl, expr, msg)
`define SAQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/saq_pkg.sv =====
// shared types and constants of the sorted alarm queue
package saq_pkg;

  localparam int OP_W        = 3;
  localparam int IDX_W       = 4;
  localparam int PAGE_W      = 3;
  localparam int FIELD_W     = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int ERR_W       = 2;
  localparam int BASE_W      = 5;
  localparam int PAGE_SIZE   = 3;
  // highest position a page read can reach, plus one
  localparam int PAGE_REACH  = (1 << PAGE_W) * PAGE_SIZE;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CHECK  = 3'd2,
    OP_OFF    = 3'd3,
    OP_PAGE   = 3'd4
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_INDEX = 2'd2
  } err_t;

  // per-beat command broadcast to every cell
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic [IDX_W-1:0] rem_idx;
  } cell_ctl_t;

endpackage

// ===== src/saq_channels.sv =====
// command and result channel interfaces of the sorted alarm queue
interface saq_in_if;
  logic                          valid;
  logic                          ready;
  logic [saq_pkg::OP_W-1:0]      op;
  logic [saq_pkg::FIELD_W-1:0]   wake_time;
  logic [saq_pkg::IDX_W-1:0]     remove_pos;
  logic [saq_pkg::FIELD_W-1:0]   now_time;
  logic [saq_pkg::PAGE_W-1:0]    page_number;

  modport source (output valid, op, wake_time, remove_pos, now_time, page_number,
                  input ready);
  modport sink   (input valid, op, wake_time, remove_pos, now_time, page_number,
                  output ready);
endinterface

interface saq_out_if;
  logic                            valid;
  logic                            ready;
  logic                            alarm_active;
  logic [saq_pkg::FIELD_W-1:0]     next_alarm;
  logic [saq_pkg::FIELD_W-1:0]     entry_first;
  logic [saq_pkg::FIELD_W-1:0]     entry_second;
  logic [saq_pkg::FIELD_W-1:0]     entry_third;
  logic                            first_page;
  logic                            last_page;
  logic [saq_pkg::COUNT_OUT_W-1:0] alarm_count;
  logic [saq_pkg::ERR_W-1:0]       error_code;

  modport source (output valid, alarm_active, next_alarm, entry_first, entry_second,
                  entry_third, first_page, last_page, alarm_count, error_code,
                  input ready);
  modport sink   (input valid, alarm_active, next_alarm, entry_first, entry_second,
                  entry_third, first_page, last_page, alarm_count, error_code,
                  output ready);
endinterface

// ===== src/saq_cell.sv =====
// one slot of the sorted chain: holds a time, shifts right on insert, left on remove
module saq_cell #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = 32,
  parameter int CW        = 5
) (
  input  logic                 clk,
  input  saq_pkg::cell_ctl_t   ctl,
  input  logic [CW-1:0]        count,
  input  logic [TIME_BITS-1:0] new_time,
  input  logic [TIME_BITS-1:0] left_time,
  input  logic                 left_ins,
  input  logic [TIME_BITS-1:0] right_time,
  output logic [TIME_BITS-1:0] cell_time,
  output logic                 ins_here,
  output logic [TIME_BITS-1:0] time_nxt
);

  localparam int XW = (CW > saq_pkg::IDX_W) ? CW : saq_pkg::IDX_W;

  logic [TIME_BITS-1:0] time_r;
  logic                 occ;
  logic                 at_end;
  logic                 rem_here;

  assign occ    = CW'(IDX) < count;
  assign at_end = CW'(IDX) == count;

  // insert position is the first occupied slot holding a later time, or the end
  assign ins_here = ctl.ins_en && ((occ && (time_r > new_time)) || at_end);
  assign rem_here = ctl.rem_en && (XW'(IDX) >= XW'(ctl.rem_idx));

  always_comb begin
    time_nxt = time_r;
    priority if (ins_here) begin
      time_nxt = left_ins ? left_time : new_time;
    end else if (rem_here) begin
      time_nxt = right_time;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
  end

  assign cell_time = time_r;

endmodule

// ===== src/sorted_alarm_queue.sv =====
// sorted alarm queue top level: control, cell chain and result register
//
//  channel  dir  iface       beat moves
//  -------  ---  ----------  -----------------------------------------------
//  in_ch    in   saq_in_if   one command: op, wake_time, position, now, page
//  out_ch   out  saq_out_if  one result per command: flags, entries, count
//
//  one command per cycle unless out_ch stalls: every cell compares and shifts in the
//  accepting cycle; the result is registered and shows in the cycle after the beat
//  rst_n (synchronous) empties the queue and clears the ringing flag; the cells
//  themselves are not cleared, slots at or above the count are never read
//  the input is held off while rst_n is low
//  a new command is taken while the previous result waits, as long as that
//  result leaves in the same cycle; a stalled result holds the input off
module sorted_alarm_queue #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  saq_in_if.sink    in_ch,
  saq_out_if.source out_ch
);

  `include "sorted_alarm_queue_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = TIME_BITS;
  localparam int FW = saq_pkg::FIELD_W;
  // widest of count, index and page base, for compares
  localparam int XW0 = (CW > saq_pkg::IDX_W) ? CW : saq_pkg::IDX_W;
  localparam int XW  = (XW0 > saq_pkg::BASE_W) ? XW0 : saq_pkg::BASE_W;
  // only the cells a page read can reach take part in the read
  localparam int RD = (DEPTH < saq_pkg::PAGE_REACH) ? DEPTH : saq_pkg::PAGE_REACH;

  // control state
  logic [CW-1:0] count_r, count_nxt;
  logic          ring_r, ring_nxt;
  logic          out_valid_r;

  // result payload registers
  logic                            active_r;
  logic [FW-1:0]                   next_alarm_r;
  logic [FW-1:0]                   ent_r [3];
  logic                            first_r;
  logic                            last_r;
  logic [saq_pkg::COUNT_OUT_W-1:0] count_out_r;
  saq_pkg::err_t                   err_r;

  // beat handshake
  logic acc;
  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;

  // fields trimmed or widened to the stored time width
  logic [TW-1:0] new_time;
  logic [TW-1:0] now_time;
  assign new_time = TW'(in_ch.wake_time);
  assign now_time = TW'(in_ch.now_time);

  // cell chain
  saq_pkg::cell_ctl_t ctl;
  logic [TW-1:0]      cell_time [DEPTH];
  logic [TW-1:0]      cell_nxt  [DEPTH];
  logic               ins_flag  [DEPTH];
  logic [TW-1:0]      left_time [DEPTH];
  logic               left_ins  [DEPTH];
  logic [TW-1:0]      right_time[DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_time[g] = '0;
      assign left_ins[g]  = 1'b0;
    end else begin : g_link
      assign left_time[g] = cell_time[g-1];
      assign left_ins[g]  = ins_flag[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      // the vacated last slot holds whatever it had
      assign right_time[g] = cell_time[g];
    end else begin : g_next
      assign right_time[g] = cell_time[g+1];
    end

    saq_cell #(
      .IDX      (g),
      .TIME_BITS(TW),
      .CW       (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .new_time  (new_time),
      .left_time (left_time[g]),
      .left_ins  (left_ins[g]),
      .right_time(right_time[g]),
      .cell_time (cell_time[g]),
      .ins_here  (ins_flag[g]),
      .time_nxt  (cell_nxt[g])
    );
  end

  // command decode
  logic          full;
  logic          idx_ok;
  logic          due;
  logic          active;
  logic          rd_en;
  saq_pkg::err_t err;

  assign full   = count_r == CW'(DEPTH);
  assign idx_ok = XW'(in_ch.remove_pos) < XW'(count_r);
  // earliest alarm at or before now
  assign due    = (count_r != '0) && (cell_time[0] <= now_time);

  always_comb begin
    ctl       = '0;
    count_nxt = count_r;
    ring_nxt  = ring_r;
    err       = saq_pkg::ERR_OK;
    active    = 1'b0;
    rd_en     = 1'b0;
    if (acc) begin
      unique case (in_ch.op)
        saq_pkg::OP_INSERT: begin
          if (full) begin
            err = saq_pkg::ERR_FULL;
          end else begin
            ctl.ins_en = 1'b1;
            count_nxt  = count_r + CW'(1);
          end
        end
        saq_pkg::OP_REMOVE: begin
          if (!idx_ok) begin
            err = saq_pkg::ERR_INDEX;
          end else begin
            ctl.rem_en  = 1'b1;
            ctl.rem_idx = in_ch.remove_pos;
            count_nxt   = count_r - CW'(1);
          end
        end
        saq_pkg::OP_CHECK: begin
          // already ringing: report only; else pop a due head and latch
          if (ring_r) begin
            active = 1'b1;
          end else if (due) begin
            ctl.rem_en  = 1'b1;
            ctl.rem_idx = '0;
            count_nxt   = count_r - CW'(1);
            ring_nxt    = 1'b1;
            active      = 1'b1;
          end
        end
        saq_pkg::OP_OFF: begin
          ring_nxt = 1'b0;
        end
        saq_pkg::OP_PAGE: begin
          rd_en = 1'b1;
        end
        default: begin
          // unused codes change nothing
        end
      endcase
    end
  end

  // page read: each reachable cell matches its own position against the page
  logic [saq_pkg::BASE_W-1:0] base;
  logic [TW-1:0]              ent [3];
  logic                       first_pg;
  logic                       last_pg;

  assign base = saq_pkg::BASE_W'(in_ch.page_number) * saq_pkg::BASE_W'(saq_pkg::PAGE_SIZE);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ent[k] = '0;
    end
    for (int i = 0; i < RD; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (rd_en && (CW'(i) < count_r) &&
            (saq_pkg::BASE_W'(i) == base + saq_pkg::BASE_W'(k))) begin
          ent[k] = ent[k] | cell_time[i];
        end
      end
    end
  end

  assign first_pg = rd_en && (in_ch.page_number == '0);
  // page equals count/3 exactly when base <= count < base + 3
  assign last_pg  = rd_en && (XW'(count_r) >= XW'(base)) &&
                    (XW'(count_r) < XW'(base) + XW'(saq_pkg::PAGE_SIZE));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ring_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ring_r      <= ring_nxt;
      out_valid_r <= acc || (out_valid_r && !out_ch.ready);
    end
  end

  // result payload, loaded on each command beat
  always_ff @(posedge clk) begin
    if (acc) begin
      active_r     <= active;
      next_alarm_r <= (count_nxt != '0) ? FW'(cell_nxt[0]) : '0;
      for (int k = 0; k < 3; k++) begin
        ent_r[k] <= FW'(ent[k]);
      end
      first_r      <= first_pg;
      last_r       <= last_pg;
      count_out_r  <= saq_pkg::COUNT_OUT_W'(count_nxt);
      err_r        <= err;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.alarm_active = active_r;
  assign out_ch.next_alarm   = next_alarm_r;
  assign out_ch.entry_first  = ent_r[0];
  assign out_ch.entry_second = ent_r[1];
  assign out_ch.entry_third  = ent_r[2];
  assign out_ch.first_page   = first_r;
  assign out_ch.last_page    = last_r;
  assign out_ch.alarm_count  = count_out_r;
  assign out_ch.error_code   = err_r;

  // beats watched by the checks below
  logic full_ins;
  logic check_beat;
  assign full_ins   = acc && (in_ch.op == saq_pkg::OP_INSERT) && full;
  assign check_beat = acc && (in_ch.op == saq_pkg::OP_CHECK);

  `SAQ_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "count beyond depth")
  `SAQ_ASSERT_NEXT(a_full_drop, full_ins, $stable(count_r), "full insert changed count")
  `SAQ_ASSERT_NEXT(a_result_follows, acc, out_valid_r, "command beat gave no result")
  `SAQ_ASSERT_ALWAYS(a_ring_from_check, !$rose(ring_r) || $past(check_beat), "ring without check")

endmodule
